// File: rtl/core/sad_stereo_disparity_unit_macros.svh
// Assertion macros shared by the disparity unit's RTL.
`ifndef SAD_STEREO_DISPARITY_UNIT_MACROS_SVH
`define SAD_STEREO_DISPARITY_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define SSD_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define SSD_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/core/ssd_pkg.sv
// Package of the SAD stereo disparity unit: constants, register codes, types.
package ssd_pkg;

    // Build defaults
    localparam int MAX_RADIUS_DEF = 3;
    localparam int MAX_DISP_DEF   = 32;
    localparam int MAX_WIDTH_DEF  = 1024;

    // Fixed widths
    localparam int PIX_W     = 8;
    localparam int ROW_W     = 10;
    localparam int DISP_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // Arithmetic constants
    localparam int EDGE_PENALTY = 10000;
    localparam int MAX_ROWS     = 1024;
    localparam int SCALE_SHIFT  = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd4;

    // Register reset values
    localparam logic [1:0]  RST_RADIUS = 2'd1;
    localparam logic [5:0]  RST_RANGE  = 6'd30;
    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [10:0] RST_HEIGHT = 11'd480;
    localparam logic        RST_SCALE  = 1'b1;

    // Control broadcast along the cell chain
    typedef struct packed {
        logic             clr;
        logic             shift;
        logic             acc;
        logic [PIX_W-1:0] right;
    } t_cell_ctl;

endpackage

// File: rtl/core/ssd_cell.sv
// One disparity cell: left pixel shift stage and window cost accumulator.
module ssd_cell #(
    parameter int SUMW = 19
) (
    input  logic                    i_clk,
    input  ssd_pkg::t_cell_ctl      i_ctl,
    input  logic [ssd_pkg::PIX_W-1:0] i_left,
    input  logic                    i_lv,
    output logic [ssd_pkg::PIX_W-1:0] o_left,
    output logic                    o_lv,
    output logic [SUMW-1:0]         o_sum
);
    import ssd_pkg::*;

    logic [PIX_W-1:0] r_left;
    logic             r_lv;
    logic [SUMW-1:0]  r_sum;
    logic [PIX_W-1:0] w_diff;
    logic [SUMW-1:0]  w_term;

    // Absolute difference, or the edge penalty past the right border
    assign w_diff = (i_left > i_ctl.right) ? (i_left - i_ctl.right) : (i_ctl.right - i_left);
    assign w_term = i_lv ? SUMW'(w_diff) : SUMW'(EDGE_PENALTY);

    // Pass the left pixel to the next cell
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_left <= i_left;
            r_lv   <= i_lv;
        end
    end

    // Accumulate the window cost
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= r_sum + w_term;
        end
    end

    assign o_left = r_left;
    assign o_lv   = r_lv;
    assign o_sum  = r_sum;
endmodule

// File: rtl/core/ssd_line_store.sv
// Line stores of the right and left images, one write and one read port.
module ssd_line_store #(
    parameter int DEPTH = 7168,
    parameter int AW    = 13
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ssd_pkg::PIX_W-1:0] i_wright,
    input  logic [ssd_pkg::PIX_W-1:0] i_wleft,
    input  logic [AW-1:0]             i_raddr,
    output logic [ssd_pkg::PIX_W-1:0] o_rright,
    output logic [ssd_pkg::PIX_W-1:0] o_rleft
);
    import ssd_pkg::*;

    logic [PIX_W-1:0] r_mem_right [DEPTH];
    logic [PIX_W-1:0] r_mem_left  [DEPTH];

    // Write the incoming pixel pair
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_right[i_waddr] <= i_wright;
            r_mem_left[i_waddr]  <= i_wleft;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        o_rright <= r_mem_right[i_raddr];
        o_rleft  <= r_mem_left[i_raddr];
    end
endmodule

// File: rtl/core/sad_stereo_disparity_unit.sv
// Top level of the SAD block-matching stereo disparity unit.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    right, left pixel pair
//  m_axis    out  m_axis_tvalid/m_axis_tready    row, column, disparity, tlast
//  cfg       in   i_cfg_valid/o_cfg_ready        register index, data
//
// Each result clears the cells, streams the 2r+1 window rows through the
// cell chain, 2r+D columns per row, one column read per cycle from the
// line store, drains the chain, searches the D cell sums for the minimum
// and is emitted. The input is accepted only in idle, between items; a
// result waiting in the output register holds the next one at the emit
// step, and the input with it. Reset restores the configuration defaults,
// clears position, state and output valid; line stores are not cleared.
`include "sad_stereo_disparity_unit_macros.svh"

module sad_stereo_disparity_unit #(
    parameter int MAX_RADIUS = ssd_pkg::MAX_RADIUS_DEF,
    parameter int MAX_DISP   = ssd_pkg::MAX_DISP_DEF,
    parameter int MAX_WIDTH  = ssd_pkg::MAX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] right_pixel, [15:8] left_pixel
    input  logic [ssd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [9:0] out_row, [19:10] out_column, [27:20] disparity_value, [31:28] zero
    output logic [ssd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ssd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ssd_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import ssd_pkg::*;

    localparam int SLOTS = 2 * MAX_RADIUS + 1;
    localparam int DEPTH = SLOTS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 2 * MAX_RADIUS + MAX_DISP + 1);
    localparam int DCW   = $clog2(MAX_DISP);
    localparam int SW    = $clog2(SLOTS);
    localparam int SUMW  = $clog2(SLOTS * SLOTS * EDGE_PENALTY + 1);
    localparam int HW    = ROW_W + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    // Configuration registers
    logic [1:0]  r_cfg_rad;
    logic [5:0]  r_cfg_range;
    logic [10:0] r_cfg_width;
    logic [10:0] r_cfg_height;
    logic        r_cfg_scale;

    // Position and sequencer state
    logic [XW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [SW-1:0]    r_slot;
    logic [2:0]       r_state;
    logic [CW-1:0]    r_j;
    logic [CW-1:0]    r_jhi;
    logic [ROW_W-1:0] r_i;
    logic [SW-1:0]    r_base;
    logic [SW-1:0]    r_yslot;
    logic [SW-1:0]    r_y;
    logic [CW-1:0]    r_c;
    logic [DCW-1:0]   r_d;
    logic [SUMW-1:0]  r_best;
    logic [DCW-1:0]   r_win;
    logic             r_pv;
    logic             r_p_lv;
    logic             r_p_acc;

    // Output register
    logic             r_out_valid;
    logic [ROW_W-1:0] r_out_row;
    logic [ROW_W-1:0] r_out_col;
    logic [DISP_W-1:0] r_out_disp;
    logic             r_out_last;

    // Effective settings
    logic [CW-1:0]  w_rad;
    logic [CW-1:0]  w_nd;
    logic [CW-1:0]  w_wid;
    logic [HW-1:0]  w_hgt;
    logic [CW-1:0]  w_two_r;
    logic [CW-1:0]  w_span;

    // Accept-time values
    logic           w_in_acc;
    logic [CW-1:0]  n_col_p;
    logic [HW-1:0]  n_row_p;
    logic [SW-1:0]  n_slot_p;
    logic [CW-1:0]  n_col;
    logic [HW-1:0]  n_row;
    logic [SW-1:0]  n_slot;
    logic [CW-1:0]  w_c1;
    logic [CW-1:0]  w_jlo;
    logic [CW-1:0]  w_jhi;
    logic           w_have;
    logic [SW:0]    w_base_t;
    logic [SW-1:0]  w_base;
    logic [AW-1:0]  w_waddr;
    logic [AW-1:0]  w_raddr;
    logic [CW-1:0]  w_start;
    logic           w_load;
    logic [DCW+SCALE_SHIFT-1:0] w_scaled;
    logic [DISP_W-1:0] w_disp;
    logic [SUMW-1:0] w_sel;

    // Cell chain
    t_cell_ctl        w_ctl;
    logic [PIX_W-1:0] w_rd_right;
    logic [PIX_W-1:0] w_rd_left;
    logic [PIX_W-1:0] w_left  [MAX_DISP+1];
    logic             w_lv    [MAX_DISP+1];
    logic [SUMW-1:0]  w_sum   [MAX_DISP];

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rad    <= RST_RADIUS;
            r_cfg_range  <= RST_RANGE;
            r_cfg_width  <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_scale  <= RST_SCALE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIUS: r_cfg_rad    <= i_cfg_data[1:0];
                CFG_RANGE:  r_cfg_range  <= i_cfg_data[5:0];
                CFG_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg_height <= i_cfg_data;
                CFG_SCALE:  r_cfg_scale  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp settings to their working ranges
    always_comb begin
        w_rad = (CW'(r_cfg_rad) > CW'(MAX_RADIUS)) ? CW'(MAX_RADIUS) : CW'(r_cfg_rad);
        if (r_cfg_range == '0) begin
            w_nd = CW'(1);
        end else if (r_cfg_range > MAX_DISP) begin
            w_nd = CW'(MAX_DISP);
        end else begin
            w_nd = CW'(r_cfg_range);
        end
        if (r_cfg_width == '0) begin
            w_wid = CW'(1);
        end else if (r_cfg_width > MAX_WIDTH) begin
            w_wid = CW'(MAX_WIDTH);
        end else begin
            w_wid = CW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            w_hgt = HW'(1);
        end else if (r_cfg_height > MAX_ROWS) begin
            w_hgt = HW'(MAX_ROWS);
        end else begin
            w_hgt = r_cfg_height;
        end
        w_two_r = w_rad << 1;
        w_span  = w_two_r + w_nd;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Wrap the position, store it, then advance it
    always_comb begin
        n_col_p  = CW'(r_col);
        n_row_p  = HW'(r_row);
        n_slot_p = r_slot;
        if (n_col_p >= w_wid) begin
            n_col_p  = '0;
            n_row_p  = n_row_p + 1'b1;
            n_slot_p = (n_slot_p == SW'(SLOTS - 1)) ? '0 : n_slot_p + 1'b1;
        end
        if (n_row_p >= w_hgt) begin
            n_row_p  = '0;
            n_slot_p = '0;
        end
        n_col  = n_col_p + 1'b1;
        n_row  = n_row_p;
        n_slot = n_slot_p;
        if (n_col >= w_wid) begin
            n_col  = '0;
            n_row  = n_row + 1'b1;
            n_slot = (n_slot == SW'(SLOTS - 1)) ? '0 : n_slot + 1'b1;
            if (n_row >= w_hgt) begin
                n_row  = '0;
                n_slot = '0;
            end
        end
    end

    // Range of window centers this pixel completes
    always_comb begin
        w_c1  = n_col_p + 1'b1;
        w_jlo = w_rad;
        w_jhi = w_rad;
        w_have = 1'b0;
        if (w_c1 < w_wid) begin
            if (w_c1 >= w_span) begin
                w_jlo  = w_c1 - w_rad - w_nd;
                w_jhi  = w_jlo;
                w_have = 1'b1;
            end
        end else begin
            w_jlo  = (w_wid >= w_span) ? (w_wid - w_rad - w_nd) : w_rad;
            w_jhi  = w_wid - 1'b1 - w_rad;
            w_have = 1'b1;
        end
        if (n_row_p < HW'(w_two_r) || w_wid <= w_two_r) begin
            w_have = 1'b0;
        end
        w_base_t = (SW + 1)'(n_slot_p) + (SW + 1)'(SLOTS) - (SW + 1)'(w_two_r);
        w_base   = (w_base_t >= (SW + 1)'(SLOTS)) ? SW'(w_base_t - (SW + 1)'(SLOTS))
                                                   : SW'(w_base_t);
    end

    assign w_waddr = AW'(n_slot_p) * AW'(MAX_WIDTH) + AW'(n_col_p[XW-1:0]);
    assign w_raddr = AW'(r_yslot) * AW'(MAX_WIDTH) + AW'(r_c[XW-1:0]);
    assign w_start = r_j + w_rad + w_nd - 1'b1;
    assign w_sel   = w_sum[r_d];
    assign w_load  = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);

    // Scale the winner for display when scaling is on, saturating
    assign w_scaled = {r_win, {SCALE_SHIFT{1'b0}}};
    always_comb begin
        if (!r_cfg_scale) begin
            w_disp = DISP_W'(r_win);
        end else if (w_scaled > 255) begin
            w_disp = '1;
        end else begin
            w_disp = DISP_W'(w_scaled);
        end
    end

    // Hold the input position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
        end else if (w_in_acc) begin
            r_col  <= XW'(n_col);
            r_row  <= ROW_W'(n_row);
            r_slot <= n_slot;
        end
    end

    // Flag a column read in flight toward the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= (r_state == ST_RUN);
        end
    end

    // Sequence window streaming, minimum search and emission
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && w_have) begin
                        r_j     <= w_jlo;
                        r_jhi   <= w_jhi;
                        r_i     <= ROW_W'(n_row_p - HW'(w_rad));
                        r_base  <= w_base;
                        r_state <= ST_CLEAR;
                    end
                end
                ST_CLEAR: begin
                    r_y     <= '0;
                    r_yslot <= r_base;
                    r_c     <= w_start;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_p_lv  <= (r_c < w_wid);
                    r_p_acc <= (r_c <= r_j + w_rad);
                    if (r_c == r_j - w_rad) begin
                        if (CW'(r_y) == w_two_r) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_y     <= r_y + 1'b1;
                            r_yslot <= (r_yslot == SW'(SLOTS - 1)) ? '0 : r_yslot + 1'b1;
                            r_c     <= w_start;
                        end
                    end else begin
                        r_c <= r_c - 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_d     <= '0;
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (r_d == '0 || w_sel < r_best) begin
                        r_best <= w_sel;
                        r_win  <= r_d;
                    end
                    if (CW'(r_d) == w_nd - 1'b1) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        if (r_j == r_jhi) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= ST_CLEAR;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_row  <= r_i;
            r_out_col  <= ROW_W'(r_j);
            r_out_disp <= w_disp;
            r_out_last <= (r_j == r_jhi);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = M_TDATA_W'({r_out_disp, r_out_col, r_out_row});

    // Line stores
    ssd_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_in_acc),
        .i_waddr  (w_waddr),
        .i_wright (s_axis_tdata[PIX_W-1:0]),
        .i_wleft  (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_raddr  (w_raddr),
        .o_rright (w_rd_right),
        .o_rleft  (w_rd_left)
    );

    // Broadcast control to the chain
    assign w_ctl.clr   = (r_state == ST_CLEAR);
    assign w_ctl.shift = r_pv;
    assign w_ctl.acc   = r_pv && r_p_acc;
    assign w_ctl.right = w_rd_right;
    assign w_left[0]   = w_rd_left;
    assign w_lv[0]     = r_p_lv;

    for (genvar g = 0; g < MAX_DISP; g++) begin : g_cell
        ssd_cell #(
            .SUMW (SUMW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_left (w_left[g]),
            .i_lv   (w_lv[g]),
            .o_left (w_left[g+1]),
            .o_lv   (w_lv[g+1]),
            .o_sum  (w_sum[g])
        );
    end

    // Checks
    `SSD_ASSERT_IMP(a_load_free, w_load, !r_out_valid || m_axis_tready)
    `SSD_ASSERT_IMP(a_cmp_range, r_state == ST_CMP, CW'(r_d) < w_nd)
    `SSD_ASSERT_IMP(a_slot_range, w_in_acc, r_slot < SLOTS)
    `SSD_ASSERT_NXT(a_no_result_idle, w_in_acc && !w_have, r_state == ST_IDLE)

endmodule

// File: tb/sad_stereo_disparity_unit_tb.sv
// Self-checking testbench for the SAD stereo disparity unit.
`timescale 1ns / 100ps

module sad_stereo_disparity_unit_tb;
    import ssd_pkg::*;

    localparam int SLOTS   = 2 * MAX_RADIUS_DEF + 1;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [DISP_W-1:0] disp;
        logic              tail;
    } t_disp_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    sad_stereo_disparity_unit dut (.*);

    // Pixel pairs waiting to be offered, disparities still owed by the block
    logic [S_TDATA_W-1:0] pixel_q[$];
    t_disp_result         disparity_q[$];

    // Predictor state
    logic [7:0]  right_rows[SLOTS*MAX_WIDTH_DEF];
    logic [7:0]  left_rows[SLOTS*MAX_WIDTH_DEF];
    int unsigned pos_col = 0, pos_row = 0;
    int unsigned cf_radius = RST_RADIUS, cf_range = RST_RANGE;
    int unsigned cf_width = RST_WIDTH, cf_height = RST_HEIGHT, cf_scale = RST_SCALE;

    int unsigned errors = 0, pixels_sent = 0, results_seen = 0, settings_run = 0;
    int unsigned idle_pct = 27;
    int unsigned hold_cnt = 0;
    bit          hold_done = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned clamp_nz(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned slot_of(int unsigned row, int unsigned col);
        return (row % SLOTS) * MAX_WIDTH_DEF + (col % MAX_WIDTH_DEF);
    endfunction

    // Winning disparity of one interior pixel, lower disparity on a tie
    function automatic int unsigned match_disparity(int unsigned i, int unsigned j,
            int unsigned r, int unsigned nd, int unsigned w);
        int unsigned best, win, sum, lc;
        int a, b;
        best = 99999999;
        win = 0;
        for (int unsigned d = 0; d < nd; d++) begin
            sum = 0;
            for (int unsigned yy = i - r; yy <= i + r; yy++) begin
                for (int unsigned xx = j - r; xx <= j + r; xx++) begin
                    lc = xx + d;
                    if (lc < w) begin
                        a = int'(right_rows[slot_of(yy, xx)]);
                        b = int'(left_rows[slot_of(yy, lc)]);
                        sum += (a > b) ? a - b : b - a;
                    end else begin
                        sum += EDGE_PENALTY;
                    end
                end
            end
            if (sum < best) begin
                best = sum;
                win = d;
            end
        end
        return win;
    endfunction

    // Store one pixel pair and queue the disparities it releases
    task automatic predict_disparities(input logic [S_TDATA_W-1:0] pair);
        int unsigned r, nd, w, h, row, c, jlo, jhi, v;
        int n;
        t_disp_result res;
        r = cf_radius;
        nd = clamp_nz(cf_range, MAX_DISP_DEF);
        w = clamp_nz(cf_width, MAX_WIDTH_DEF);
        h = clamp_nz(cf_height, MAX_ROWS);
        n = 0;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
        row = pos_row;
        c = pos_col;
        right_rows[slot_of(row, c)] = pair[7:0];
        left_rows[slot_of(row, c)] = pair[15:8];
        if (row >= 2 * r && w > 2 * r) begin
            if (c + 1 < w) begin
                if (c + 1 >= 2 * r + nd) begin
                    jlo = c + 1 - r - nd;
                    jhi = jlo;
                end else begin
                    jlo = 1;
                    jhi = 0;
                end
            end else begin
                jlo = (w >= 2 * r + nd) ? w - r - nd : r;
                jhi = w - 1 - r;
            end
            for (int unsigned j = jlo; j <= jhi && j >= r; j++) begin
                v = match_disparity(row - r, j, r, nd, w);
                if (cf_scale != 0) begin
                    v = v * 8;
                    if (v > 255) v = 255;
                end
                res.row = ROW_W'(row - r);
                res.col = ROW_W'(j);
                res.disp = v[7:0];
                res.tail = 1'b0;
                disparity_q.push_back(res);
                n++;
            end
            if (n > 0) disparity_q[disparity_q.size()-1].tail = 1'b1;
        end
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h) pos_row = 0;
        end
    endtask

    // Offer pixel pairs, hold each until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                s_axis_tdata  <= pixel_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Predict on every accepted pixel pair
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_disparities(s_axis_tdata);
            pixels_sent++;
        end
    end

    // Check results, stall the output at random and once for a long stretch
    always @(posedge i_clk) begin
        t_disp_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (disparity_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual row %0d col %0d disp %0d last %0b",
                         $time, m_axis_tdata[9:0], m_axis_tdata[19:10],
                         m_axis_tdata[27:20], m_axis_tlast);
            end else begin
                want = disparity_q.pop_front();
                if (m_axis_tdata[9:0] !== want.row || m_axis_tdata[19:10] !== want.col ||
                    m_axis_tdata[27:20] !== want.disp || m_axis_tlast !== want.tail) begin
                    errors++;
                    $display("%0t: mismatch, expected row %0d col %0d disp %0d last %0b",
                             $time, want.row, want.col, want.disp, want.tail);
                    $display("%0t:           actual row %0d col %0d disp %0d last %0b",
                             $time, m_axis_tdata[9:0], m_axis_tdata[19:10],
                             m_axis_tdata[27:20], m_axis_tlast);
                end
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen == 2) begin
            hold_done <= 1'b1;
            hold_cnt <= 3000;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Wait until every pixel is taken and every disparity has come back
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixel_q.size() != 0 || s_axis_tvalid || disparity_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Offer one register write and hold it until taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_DAT_W-1:0];
        do @(posedge i_clk);
        while (!o_cfg_ready);
        case (idx)
            CFG_RADIUS: cf_radius = value & 32'h3;
            CFG_RANGE:  cf_range = value & 32'h3F;
            CFG_WIDTH:  cf_width = value & 32'h7FF;
            CFG_HEIGHT: cf_height = value & 32'h7FF;
            CFG_SCALE:  cf_scale = value & 32'h1;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned r, d, w, h, s);
        wait_idle();
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_RANGE, d);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_SCALE, s);
        i_cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // Queue one whole frame: left is right shifted by a disparity, plus noise, or pure random
    task automatic queue_frame(input int unsigned w, h, shift, noise, bit pure_random);
        logic [7:0] rrow[MAX_WIDTH_DEF];
        logic [7:0] lp;
        int unsigned pick;
        for (int unsigned y = 0; y < h; y++) begin
            for (int unsigned x = 0; x < w; x++) rrow[x] = 8'($urandom_range(255));
            for (int unsigned x = 0; x < w; x++) begin
                pick = $urandom_range(noise);
                if (pure_random || x < shift) lp = 8'($urandom_range(255));
                else lp = rrow[x-shift] + pick[7:0];
                pixel_q.push_back({lp, rrow[x]});
            end
        end
    endtask

    initial begin
        int unsigned r, d, w, h, rnd_pixels;
        logic [7:0] edge_val[4];
        edge_val = '{8'h00, 8'hFF, 8'hAA, 8'h55};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Radius 0 and zero range, width and height: every pixel is interior;
        // the output stall lands here
        apply_setting(0, 0, 0, 0, 0);
        for (int k = 0; k < 16; k++) pixel_q.push_back({edge_val[k/4], edge_val[k%4]});

        // Smallest image, one interior pixel
        apply_setting(1, 3, 3, 3, 1);
        for (int k = 0; k < 9; k++) pixel_q.push_back({edge_val[(k+1)%4], edge_val[k%4]});
        queue_frame(3, 3, 1, 0, 0);
        queue_frame(3, 3, 0, 3, 0);

        // Widest window, full search range, and a range that clamps
        apply_setting(3, 32, 12, 7, 1);
        queue_frame(12, 7, 2, 4, 0);
        apply_setting(2, 63, 10, 6, 0);
        idle_pct = 0;
        queue_frame(10, 6, 5, 0, 0);

        // Width past the maximum on a single line, part of one row
        apply_setting(0, 1, 2047, 1, 1);
        idle_pct = 27;
        for (int k = 0; k < 24; k++) pixel_q.push_back(16'($urandom));

        // A one-pixel frame brings the position back to the first row
        apply_setting(0, 1, 1, 1, 0);
        pixel_q.push_back(16'h3C5A);

        // Random settings and frames, mostly matchable with a true shift
        rnd_pixels = 0;
        while (rnd_pixels < 40) begin
            r = $urandom_range(2);
            d = $urandom_range(12, 1);
            w = $urandom_range(2 * r + 8, 2 * r + 1);
            h = $urandom_range(2 * r + 3, 2 * r + 1);
            apply_setting(r, d, w, h, $urandom_range(1));
            idle_pct = ($urandom_range(3) == 0) ? 0 : 27;
            queue_frame(w, h, $urandom_range(d - 1), $urandom_range(3) * 3,
                        $urandom_range(4) == 0);
            rnd_pixels += w * h;
        end

        wait_idle();
        $display("Covered %0d pixel pairs and %0d disparities over %0d register settings.",
                 pixels_sent, results_seen, settings_run);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
